FILE: design/lfo_pkg.sv
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared types, codes and elaboration-time tables for the LFO block:
// quarter-wave sine table, LFSR transition matrices and random draw mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_pkg;

    // Fixed widths
    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int TAB_N           = 1 << SINE_TABLE_BITS;
    localparam int TAB_AW          = SINE_TABLE_BITS + 1;
    localparam int MAG_BITS        = SAMPLE_BITS - 1;
    localparam int INC_BITS        = 31;
    localparam int SKIP_BITS       = 16;
    localparam int AMT_BITS        = INC_BITS + SKIP_BITS;

    localparam logic [MAG_BITS-1:0] FULL_SCALE = {MAG_BITS{1'b1}};

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] LFSR_SEED   = 32'h1234_5678;
    localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_PHASE_INC = 2'd0,
        REG_WAVEFORM  = 2'd1,
        REG_BIPOLAR   = 2'd2
    } t_reg_idx;

    // Input beat modes
    typedef enum logic [1:0] {
        MODE_NEXT  = 2'd0,
        MODE_SKIP  = 2'd1,
        MODE_SET   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Waveform codes; codes 6 and 7 play as sine
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_STEP_RND = 3'd4;
    localparam logic [2:0] WAVE_SMTH_RND = 3'd5;

    typedef logic [TAB_N:0][MAG_BITS-1:0] t_sine_tab;
    typedef logic [31:0][31:0]            t_lfsr_mat;

    // Taylor sine of a Q30 angle in [0, pi/2], six correction terms
    function automatic longint sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        return sum;
    endfunction

    // Quarter-wave table, TAB_N + 1 points, rounded and clamped to full scale
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        longint      s;
        longint      e;
        logic [63:0] x;
        for (int k = 0; k <= TAB_N; k++) begin
            x = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            s = sin_q30(x);
            if (s < 0) begin
                s = 0;
            end
            e = (s * longint'(FULL_SCALE) + (longint'(1) <<< 29)) >>> 30;
            if (e > longint'(FULL_SCALE)) begin
                e = longint'(FULL_SCALE);
            end
            tab[k] = e[MAG_BITS-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // One Galois shift of the LFSR
    function automatic logic [31:0] lfsr_shift(input logic [31:0] w);
        logic [31:0] r;
        r = w >> 1;
        if (w[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    // Column i is the image of bit i after the given number of shifts
    function automatic t_lfsr_mat build_lfsr_mat(input int steps);
        t_lfsr_mat   m;
        logic [31:0] w;
        for (int i = 0; i < 32; i++) begin
            w = 32'(1) << i;
            for (int s = 0; s < steps; s++) begin
                w = lfsr_shift(w);
            end
            m[i] = w;
        end
        return m;
    endfunction

    localparam t_lfsr_mat LFSR_MAT1 = build_lfsr_mat(32);
    localparam t_lfsr_mat LFSR_MAT2 = build_lfsr_mat(64);

    // Linear map: XOR of the columns selected by the set bits
    function automatic logic [31:0] lfsr_apply(input t_lfsr_mat m, input logic [31:0] w);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            r = r ^ (w[i] ? m[i] : 32'd0);
        end
        return r;
    endfunction

    // Top bits less half range; most negative code raised to -FS
    function automatic logic signed [SAMPLE_BITS-1:0] draw_value(input logic [31:0] w);
        logic [SAMPLE_BITS-1:0] v;
        v = {~w[31], w[30:32-SAMPLE_BITS]};
        if (v == {1'b1, {MAG_BITS{1'b0}}}) begin
            v = {1'b1, {(MAG_BITS-1){1'b0}}, 1'b1};
        end
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

FILE: design/lfo_sine_rom.sv
// ----------------------------------------------------------------------------
// lfo_sine_rom
// Quarter-wave sine ROM with registered read data and a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_sine_rom
    import lfo_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [TAB_AW-1:0]   i_addr,
    output logic      [MAG_BITS-1:0] o_data
);

    logic [MAG_BITS-1:0] r_data;

    // Registered read; holds while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_TAB[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: design/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Phase-accumulator LFO with sine, triangle, sawtooth, square and random
// waveforms, APB register port and valid/ready sample channels.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle while o_ready is high. Each
// next-sample beat returns one Q1.15 sample once through both stages: stage 1
// reads the registered sine ROM and forms the other waveforms, stage 2 applies
// the sine sign and the unipolar mapping into the output register. Skip and
// set-phase beats update the oscillator state at acceptance and return
// nothing. Output back-pressure stalls the two-stage pipe; o_ready stays high
// while any stage can move. Registers: 0x0 phase increment (31 bits), 0x4
// waveform (3 bits), 0x8 bipolar (1 bit); write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_waveform_generator
    import lfo_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // Input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [SKIP_BITS-1:0]          i_skip_count,
    input  wire logic [PHASE_BITS-1:0]         i_new_phase,
    // Output channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out
);

    // Configuration registers
    logic [INC_BITS-1:0] r_phase_inc;
    logic [2:0]          r_waveform;
    logic                r_bipolar;

    // Oscillator state
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [SAMPLE_BITS-1:0] r_last_rnd;
    logic signed [SAMPLE_BITS-1:0] r_target_rnd;
    logic [31:0]                   r_lfsr;

    // Pipeline
    logic                          r_s1_valid;
    logic                          r_s1_sine;
    logic                          r_s1_neg;
    logic signed [SAMPLE_BITS:0]   r_s1_val;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    logic                          s1_en;
    logic                          s2_en;
    logic                          in_beat;
    logic                          cfg_wr;
    t_reg_idx                      cfg_idx;

    // ------------------------------------------------------------------------
    // APB port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_waveform  <= WAVE_SINE;
            r_bipolar   <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PHASE_INC: r_phase_inc <= pwdata[INC_BITS-1:0];
                REG_WAVEFORM:  r_waveform  <= pwdata[2:0];
                REG_BIPOLAR:   r_bipolar   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PHASE_INC: prdata = {1'b0, r_phase_inc};
            REG_WAVEFORM:  prdata = {29'd0, r_waveform};
            REG_BIPOLAR:   prdata = {31'd0, r_bipolar};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Handshake and stall control
    // ------------------------------------------------------------------------
    assign s2_en   = !r_out_valid || i_ready;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_ready = s1_en;
    assign in_beat = i_valid && o_ready;

    // ------------------------------------------------------------------------
    // Phase advance and random draws
    // ------------------------------------------------------------------------
    logic [SKIP_BITS-1:0]  adv_cnt;
    logic [AMT_BITS-1:0]   adv_amt;
    logic [AMT_BITS:0]     adv_sum;
    logic [AMT_BITS-PHASE_BITS:0] adv_wraps;
    logic                  rnd_wave;
    logic [31:0]           lfsr_1;
    logic [31:0]           lfsr_2;

    assign adv_cnt   = (t_mode'(i_mode) == MODE_NEXT) ? SKIP_BITS'(1) : i_skip_count;
    assign adv_amt   = AMT_BITS'(r_phase_inc) * AMT_BITS'(adv_cnt);
    assign adv_sum   = (AMT_BITS+1)'(r_phase) + (AMT_BITS+1)'(adv_amt);
    assign adv_wraps = adv_sum[AMT_BITS:PHASE_BITS];
    assign rnd_wave  = (r_waveform == WAVE_STEP_RND) || (r_waveform == WAVE_SMTH_RND);
    assign lfsr_1    = lfsr_apply(LFSR_MAT1, r_lfsr);
    assign lfsr_2    = lfsr_apply(LFSR_MAT2, r_lfsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_last_rnd   <= '0;
            r_target_rnd <= '0;
            r_lfsr       <= LFSR_SEED;
        end else if (in_beat) begin
            case (t_mode'(i_mode))
                MODE_NEXT, MODE_SKIP: begin
                    r_phase <= adv_sum[PHASE_BITS-1:0];
                    if (rnd_wave && adv_wraps == 1) begin
                        r_last_rnd   <= r_target_rnd;
                        r_target_rnd <= draw_value(lfsr_1);
                        r_lfsr       <= lfsr_1;
                    end else if (rnd_wave && adv_wraps > 1) begin
                        // two draws at most, however many wraps
                        r_last_rnd   <= draw_value(lfsr_1);
                        r_target_rnd <= draw_value(lfsr_2);
                        r_lfsr       <= lfsr_2;
                    end
                end
                MODE_SET: r_phase <= i_new_phase;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: waveform from the phase before it advances
    // ------------------------------------------------------------------------
    localparam logic signed [SAMPLE_BITS+1:0] FS_X = (SAMPLE_BITS+2)'(FULL_SCALE);

    logic [TAB_AW-1:0]             rom_addr;
    logic [SINE_TABLE_BITS-1:0]    rom_idx;
    logic [MAG_BITS-1:0]           rom_data;
    logic [PHASE_BITS-1:0]         tri_q;
    logic [PHASE_BITS-1:0]         mul_op;
    logic [PHASE_BITS+MAG_BITS-1:0] mul_p;
    logic signed [SAMPLE_BITS+1:0] tri_s;
    logic signed [SAMPLE_BITS+1:0] saw_s;
    logic signed [SAMPLE_BITS:0]   rnd_diff;
    logic signed [SAMPLE_BITS+17:0] rnd_prod;
    logic signed [SAMPLE_BITS+1:0] wave_val;
    logic signed [SAMPLE_BITS+1:0] tmp;

    assign rom_idx  = r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_addr = r_phase[PHASE_BITS-2] ? (TAB_AW'(TAB_N) - TAB_AW'(rom_idx))
                                            : TAB_AW'(rom_idx);

    lfo_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (s1_en),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Triangle offset within its segment
    always_comb begin
        case (r_phase[PHASE_BITS-1 -: 2])
            2'b01, 2'b10: tri_q = r_phase - {2'b01, {(PHASE_BITS-2){1'b0}}};
            default:      tri_q = {2'b00, r_phase[PHASE_BITS-3:0]};
        endcase
    end

    // Shared scaling multiply by full scale
    assign mul_op   = (r_waveform == WAVE_TRIANGLE) ? tri_q : r_phase;
    assign mul_p    = (PHASE_BITS+MAG_BITS)'(mul_op) * (PHASE_BITS+MAG_BITS)'(FULL_SCALE);
    assign tri_s    = $signed((SAMPLE_BITS+2)'(mul_p[PHASE_BITS+MAG_BITS-1:PHASE_BITS-2]));
    assign saw_s    = $signed((SAMPLE_BITS+2)'(mul_p[PHASE_BITS+MAG_BITS-1:PHASE_BITS-1]));

    // Smooth random: interpolate with the top 16 phase bits, floored
    assign rnd_diff = (SAMPLE_BITS+1)'(r_target_rnd) - (SAMPLE_BITS+1)'(r_last_rnd);
    assign rnd_prod = (SAMPLE_BITS+18)'(rnd_diff)
                    * $signed({2'b00, r_phase[PHASE_BITS-1 -: 16]});

    always_comb begin
        tmp = '0;
        case (r_waveform)
            WAVE_TRIANGLE: begin
                case (r_phase[PHASE_BITS-1 -: 2])
                    2'b00:        wave_val = tri_s;
                    2'b01, 2'b10: wave_val = FS_X - tri_s;
                    default:      wave_val = tri_s - FS_X;
                endcase
            end
            WAVE_SAW:      wave_val = saw_s - FS_X;
            WAVE_SQUARE:   wave_val = r_phase[PHASE_BITS-1] ? -FS_X : FS_X;
            WAVE_STEP_RND: wave_val = (SAMPLE_BITS+2)'(r_target_rnd);
            WAVE_SMTH_RND: begin
                tmp      = rnd_prod[SAMPLE_BITS+17:16];
                wave_val = (SAMPLE_BITS+2)'(r_last_rnd) + tmp;
            end
            default:       wave_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= in_beat && (t_mode'(i_mode) == MODE_NEXT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_sine <= !(r_waveform inside {WAVE_TRIANGLE, WAVE_SAW, WAVE_SQUARE,
                                               WAVE_STEP_RND, WAVE_SMTH_RND});
            r_s1_neg  <= r_phase[PHASE_BITS-1];
            r_s1_val  <= wave_val[SAMPLE_BITS:0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: sine sign, unipolar mapping, output register
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_BITS:0] s2_val;
    logic signed [SAMPLE_BITS:0] s2_uni;

    always_comb begin
        if (r_s1_sine) begin
            s2_val = r_s1_neg ? -$signed((SAMPLE_BITS+1)'(rom_data))
                              : $signed((SAMPLE_BITS+1)'(rom_data));
        end else begin
            s2_val = r_s1_val;
        end
        s2_uni = (s2_val + $signed((SAMPLE_BITS+1)'(FULL_SCALE))) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_sample <= r_bipolar ? s2_val[SAMPLE_BITS-1:0] : s2_uni[SAMPLE_BITS-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_sample;

endmodule

`default_nettype wire

FILE: bench/lfo_waveform_generator_tb.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator_tb
// Self-checking bench for the LFO. Beats go in on the valid/ready input
// channel. A scoreboard object follows the oscillator state: phase, random
// pair and LFSR. It predicts every next-sample beat and checks the samples
// that come out in order. The register port is written before each test
// segment while the block is idle. Both channels stall at random.
// ----------------------------------------------------------------------------
module lfo_waveform_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfo_pkg::*;

    localparam logic [3:0] ADDR_PHASE_INC = {REG_PHASE_INC, 2'b00};
    localparam logic [3:0] ADDR_WAVEFORM  = {REG_WAVEFORM, 2'b00};
    localparam logic [3:0] ADDR_BIPOLAR   = {REG_BIPOLAR, 2'b00};
    localparam logic [3:0] ADDR_UNUSED    = 4'hC;
    localparam int         DRAIN_CYCLES   = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: oscillator prediction and sample checking
    // ------------------------------------------------------------------------
    class lfo_sample_scoreboard;
        longint                  fs;
        longint                  sine_mag[0:TAB_N];
        logic [30:0]             inc;
        logic [2:0]              wave;
        logic                    bip;
        logic [31:0]             phase;
        longint                  last_rnd;
        longint                  tgt_rnd;
        logic [31:0]             lfsr;
        logic signed [15:0]      expected_samples[$];
        int                      errors;

        function new();
            longint unsigned x;
            longint          s;
            longint          e;
            fs = longint'(FULL_SCALE);
            for (int k = 0; k <= TAB_N; k++) begin
                x = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
                s = taylor_sine(x);
                if (s < 0) begin
                    s = 0;
                end
                e = (s * fs + (longint'(1) <<< 29)) >>> 30;
                sine_mag[k] = (e > fs) ? fs : e;
            end
            inc      = '0;
            wave     = WAVE_SINE;
            bip      = 1'b1;
            phase    = '0;
            last_rnd = 0;
            tgt_rnd  = 0;
            lfsr     = LFSR_SEED;
            errors   = 0;
        endfunction

        // Q30 sine, odd terms up to x^13
        function longint taylor_sine(longint unsigned x);
            longint unsigned x2;
            longint unsigned term;
            longint          sum;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / longint'(2 * k * (2 * k + 1));
                sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            return sum;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_samples.size();
        endfunction

        function void write_register(logic [3:0] addr, logic [31:0] data);
            case (addr[3:2])
                REG_PHASE_INC: inc  = data[30:0];
                REG_WAVEFORM:  wave = data[2:0];
                REG_BIPOLAR:   bip  = data[0];
                default: ;
            endcase
        endfunction

        // 32 Galois shifts, then top half less mid code
        function longint draw_target();
            longint v;
            for (int i = 0; i < 32; i++) begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            end
            v = longint'(lfsr[31:16]) - (fs + 1);
            return (v < -fs) ? -fs : v;
        endfunction

        // Phase step; a random wave redraws once per wrap, twice at most
        function void advance_phase(longint unsigned amount);
            longint unsigned sum;
            longint unsigned wraps;
            sum   = longint'(phase) + amount;
            wraps = sum >> 32;
            phase = sum[31:0];
            if (wave == WAVE_STEP_RND || wave == WAVE_SMTH_RND) begin
                for (int i = 0; i < ((wraps >= 2) ? 2 : int'(wraps)); i++) begin
                    last_rnd = tgt_rnd;
                    tgt_rnd  = draw_target();
                end
            end
        endfunction

        function longint ramp(longint unsigned frac, longint unsigned mult);
            return longint'((frac * mult * longint'(fs)) >> 32);
        endfunction

        // Bipolar value at the current phase
        function longint wave_at_phase();
            longint unsigned p;
            longint          m;
            p = longint'(phase);
            case (wave)
                WAVE_TRIANGLE: begin
                    if (p < 64'h4000_0000) begin
                        return ramp(p, 4);
                    end
                    if (p < 64'hC000_0000) begin
                        return fs - ramp(p - 64'h4000_0000, 4);
                    end
                    return -fs + ramp(p - 64'hC000_0000, 4);
                end
                WAVE_SAW:      return -fs + ramp(p, 2);
                WAVE_SQUARE:   return (p < 64'h8000_0000) ? fs : -fs;
                WAVE_STEP_RND: return tgt_rnd;
                WAVE_SMTH_RND: begin
                    return last_rnd
                         + (((tgt_rnd - last_rnd) * longint'(p >> 16)) >>> 16);
                end
                default: begin
                    // quarter-wave table, mirrored in odd quadrants, negated in upper half
                    m = phase[30] ? sine_mag[TAB_N - int'(phase[29:20])]
                                  : sine_mag[int'(phase[29:20])];
                    return phase[31] ? -m : m;
                end
            endcase
        endfunction

        // Accepted input beat
        function void note_beat(t_mode mode, logic [15:0] skip, logic [31:0] new_ph);
            longint v;
            case (mode)
                MODE_NEXT: begin
                    v = wave_at_phase();
                    advance_phase(longint'(inc));
                    if (!bip) begin
                        v = (v + fs) >>> 1;
                    end
                    expected_samples.push_back(v[15:0]);
                end
                MODE_SKIP: advance_phase(longint'(inc) * longint'(skip));
                MODE_SET:  phase = new_ph;
                default: ;
            endcase
        endfunction

        // Accepted output beat
        task check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d", got));
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("sample_out got %0d want %0d", got, want));
                end
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [3:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_ready;
    logic [1:0]                    i_mode;
    logic [SKIP_BITS-1:0]          i_skip_count;
    logic [PHASE_BITS-1:0]         i_new_phase;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;

    int send_idle = 13;
    int recv_idle = 55;

    lfo_sample_scoreboard sb = new();

    lfo_waveform_generator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_skip_count (i_skip_count),
        .i_new_phase  (i_new_phase),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: both channels sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_beat(t_mode'(i_mode), i_skip_count, i_new_phase);
            end
            if (o_valid && i_ready) begin
                sb.check_sample(o_sample_out);
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_beat(input t_mode mode, input logic [15:0] skip,
                             input logic [31:0] new_ph);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_skip_count <= skip;
        i_new_phase  <= new_ph;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Setup then access; psel is left high for a following write
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_register(addr, data);
        @(negedge i_clk);
    endtask

    // Drain the pipe, then write all registers with junk in the unused bits
    task automatic apply_config(input logic [30:0] inc, input logic [2:0] wave,
                                input logic bip);
        logic [31:0] junk;
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        junk = $urandom;
        apb_write(ADDR_PHASE_INC, {junk[31], inc});
        apb_write(ADDR_WAVEFORM, {junk[31:3], wave});
        apb_write(ADDR_BIPOLAR, {junk[31:1], bip});
        apb_write(ADDR_UNUSED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_config();
        logic [30:0] inc;
        logic [2:0]  wave;
        case ($urandom_range(5))
            0:       inc = '0;
            1:       inc = 31'h7FFF_FFFF;
            2:       inc = 31'($urandom_range(1, 1 << 16));
            3:       inc = 31'($urandom);
            default: inc = 31'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
        endcase
        wave = $urandom_range(1) ? 3'($urandom_range(WAVE_STEP_RND, WAVE_SMTH_RND))
                                 : 3'($urandom_range(7));
        apply_config(inc, wave, 1'($urandom_range(1)));
    endtask

    task automatic random_beat();
        int          r;
        t_mode       mode;
        logic [15:0] skip;
        r    = $urandom_range(99);
        mode = (r < 60) ? MODE_NEXT : (r < 75) ? MODE_SKIP : (r < 90) ? MODE_SET : MODE_NONE;
        skip = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom);
        send_beat(mode, skip, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int n;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_mode       = MODE_NEXT;
        i_skip_count = '0;
        i_new_phase  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: phase extremes and quadrant edges, alias sine code, max step
        apply_config(31'h7FFF_FFFF, 3'd7, 1'b1);
        send_beat(MODE_SET, 16'h0000, 32'h0000_0000);
        send_beat(MODE_NEXT, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(MODE_SET, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SET, 16'h0000, 32'h4000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SET, 16'h0000, 32'hC000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);

        // Smooth random, unipolar: multi-wrap skip, zero skip, single skip
        apply_config(31'h1234_5678, WAVE_SMTH_RND, 1'b0);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SKIP, 16'hFFFF, 32'h0000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SKIP, 16'h0000, 32'h0000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SKIP, 16'h0001, 32'h0000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SET, 16'h0000, 32'h8000_0000);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);

        // Triangle at zero step: just below the turning points
        apply_config(31'h0000_0000, WAVE_TRIANGLE, 1'b1);
        send_beat(MODE_SET, 16'h0000, 32'h3FFF_FFFF);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);
        send_beat(MODE_SET, 16'h0000, 32'hBFFF_FFFF);
        send_beat(MODE_NEXT, 16'h0000, 32'h0000_0000);

        // Random part over three stall profiles
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 13; recv_idle = 55; end
                1: begin send_idle = 55; recv_idle = 13; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int seg = 0; seg < 9; seg++) begin
                random_config();
                repeat (50) random_beat();
            end
        end
        i_valid <= 1'b0;

        // Drain and final verdict
        n = 0;
        while (sb.pending() != 0 && n < 2000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (4 * DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d samples never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
